// ----- sv/lag_pkg.sv -----
// Shared types and codes for the life automaton generation block.
// No dependencies; compiled first.
package lag_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COORD_W = 6;
  localparam int unsigned BOUND_W = 4;
  localparam int unsigned CFG_W   = 2;
  localparam int unsigned COUNT_W = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_W-1:0] {
    REG_SURVIVE_LOW  = 2'd0,
    REG_SURVIVE_HIGH = 2'd1,
    REG_BIRTH_LOW    = 2'd2,
    REG_BIRTH_HIGH   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BOUND_W-1:0] survive_low;
    logic [BOUND_W-1:0] survive_high;
    logic [BOUND_W-1:0] birth_low;
    logic [BOUND_W-1:0] birth_high;
  } bounds_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_GEN,
    ST_FIN
  } state_t;

endpackage

// ----- sv/lag_in_if.sv -----
// Command channel: valid/ready plus one command item.
// Depends on lag_pkg.
interface lag_in_if import lag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic               write_alive;

  modport source (output valid, command, cell_row, cell_col, write_alive, input ready);
  modport sink   (input valid, command, cell_row, cell_col, write_alive, output ready);
endinterface

// ----- sv/lag_out_if.sv -----
// Result channel: valid/ready plus one result item.
// Depends on lag_pkg.
interface lag_out_if import lag_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             read_alive;
  logic [CMD_W-1:0] done_command;

  modport source (output valid, read_alive, done_command, input ready);
  modport sink   (input valid, read_alive, done_command, output ready);
endinterface

// ----- sv/lag_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and data.
// Depends on lag_pkg.
interface lag_cfg_if import lag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_W-1:0]   index;
  logic [BOUND_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/life_automaton_generation.sv -----
// Life automaton generation block: cell grid in a two-bank RAM, streamed rule.
// Depends on lag_pkg, lag_in_if, lag_out_if, lag_cfg_if, lag_ram, lag_row_rule.
//
//   channel  dir  payload                                    transfer
//   in_chan  in   command, cell_row, cell_col, write_alive   valid & ready
//   out_chan out  read_alive, done_command                   valid & ready
//   cfg_chan in   index, data                                valid & ready
//
// Cell writes and reads go via ST_CELL; unused codes and off-grid cells go via ST_FIN.
// Advance reads rows in order, writing each new row to the other bank behind the reads;
// it then writes the last row, swaps banks and loads the result in ST_FIN.
// Reset is immediate: row valid bits make every row read as dead.
// Output stalls hold the finishing step; one command is in flight at a time.
module life_automaton_generation import lag_pkg::*; #(
  parameter int unsigned ROWS = 64,
  parameter int unsigned COLS = 64
) (
  input logic      clk,
  input logic      rst_n,
  lag_in_if.sink   in_chan,
  lag_out_if.source out_chan,
  lag_cfg_if.sink  cfg_chan
);

  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned CNTW  = $clog2(ROWS + 1);
  localparam int unsigned AW    = RW + 1;
  localparam int unsigned DEPTH = 2 ** AW;

  state_t            state_r, state_nxt;
  bounds_t           bounds_r;
  logic              sel_r;
  logic [ROWS-1:0]   vld_r;
  logic              dv_r, rvld_r;
  logic [CNTW-1:0]   rd_cnt_r, recv_cnt_r;
  logic [COLS-1:0]   above_r, cur_r;
  cmd_t              cmd_r;
  logic [RW-1:0]     row_r;
  logic [CW-1:0]     col_r;
  logic              wa_r;
  logic              out_valid_r, read_alive_r;
  cmd_t              done_cmd_r;

  logic              slot_free, in_rng;
  logic              rd_en, wr_en, load_out, out_bit, gen_done, accept;
  logic              rd_bank;
  logic [RW-1:0]     rd_row;
  logic [AW-1:0]     wr_addr;
  logic [COLS-1:0]   wr_data, ram_rd, row_data, row_mod, below, rule_row;

  assign accept    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign in_rng    = ({3'b000, in_chan.cell_row} < 9'(ROWS))
                  && ({1'b0, in_chan.cell_col} < 7'(COLS));
  assign row_data  = rvld_r ? ram_rd : '0;
  assign below     = dv_r ? row_data : '0;
  assign rd_bank   = sel_r;

  always_comb begin
    row_mod        = row_data;
    row_mod[col_r] = wa_r;
  end

  lag_ram #(.WIDTH(COLS), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr ({rd_bank, rd_row}),
    .rd_data (ram_rd)
  );

  lag_row_rule #(.COLS(COLS)) u_rule (
    .above    (above_r),
    .cur      (cur_r),
    .below    (below),
    .bounds   (bounds_r),
    .next_row (rule_row)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_chan.ready  = 1'b0;
    rd_en          = 1'b0;
    rd_row         = RW'(in_chan.cell_row);
    wr_en          = 1'b0;
    wr_addr        = {sel_r, row_r};
    wr_data        = row_mod;
    load_out       = 1'b0;
    out_bit        = 1'b0;
    gen_done       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          case (in_chan.command)
            CMD_WRITE, CMD_READ: begin
              rd_en     = in_rng;
              state_nxt = in_rng ? ST_CELL : ST_FIN;
            end
            CMD_ADVANCE: begin
              rd_en     = 1'b1;
              rd_row    = '0;
              state_nxt = ST_GEN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_CELL: begin
        if (slot_free) begin
          load_out  = 1'b1;
          out_bit   = (cmd_r == CMD_READ) && row_data[col_r];
          wr_en     = (cmd_r == CMD_WRITE);
          state_nxt = ST_IDLE;
        end
      end
      ST_GEN: begin
        rd_row  = RW'(rd_cnt_r);
        rd_en   = (rd_cnt_r < CNTW'(ROWS));
        wr_addr = {~sel_r, RW'(recv_cnt_r - 1'b1)};
        wr_data = rule_row;
        if (dv_r) begin
          wr_en = (recv_cnt_r != '0);
        end else begin
          wr_en     = 1'b1;
          gen_done  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r    <= '{survive_low: 4'd2, survive_high: 4'd3,
                       birth_low: 4'd3, birth_high: 4'd3};
      sel_r       <= 1'b0;
      vld_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r <= rd_en;
      if (cfg_chan.valid) begin
        case (cfg_idx_t'(cfg_chan.index))
          REG_SURVIVE_LOW:  bounds_r.survive_low  <= cfg_chan.data;
          REG_SURVIVE_HIGH: bounds_r.survive_high <= cfg_chan.data;
          REG_BIRTH_LOW:    bounds_r.birth_low    <= cfg_chan.data;
          REG_BIRTH_HIGH:   bounds_r.birth_high   <= cfg_chan.data;
          default: ;
        endcase
      end
      if (wr_en && state_r == ST_CELL) begin
        vld_r[row_r] <= 1'b1;
      end
      if (gen_done) begin
        sel_r <= ~sel_r;
        vld_r <= '1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and window
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvld_r <= vld_r[rd_row];
    end
    if (accept) begin
      cmd_r      <= cmd_t'(in_chan.command);
      row_r      <= RW'(in_chan.cell_row);
      col_r      <= CW'(in_chan.cell_col);
      wa_r       <= in_chan.write_alive;
      above_r    <= '0;
      cur_r      <= '0;
      recv_cnt_r <= '0;
      rd_cnt_r   <= CNTW'(1);
    end else if (state_r == ST_GEN) begin
      if (rd_en) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (dv_r) begin
        above_r    <= cur_r;
        cur_r      <= row_data;
        recv_cnt_r <= recv_cnt_r + 1'b1;
      end
    end
    if (load_out) begin
      read_alive_r <= out_bit;
      done_cmd_r   <= cmd_r;
    end
  end

  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.read_alive   = read_alive_r;
  assign out_chan.done_command = done_cmd_r;

endmodule

// ----- sv/lag_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lag_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/lag_row_rule.sv -----
// Next-generation rule for one grid row from its three-row window.
// Depends on lag_pkg.
module lag_row_rule import lag_pkg::*; #(
  parameter int unsigned COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] cur,
  input  logic [COLS-1:0] below,
  input  bounds_t         bounds,
  output logic [COLS-1:0] next_row
);

  logic [COLS+1:0] pa, pc, pb;

  assign pa = {1'b0, above, 1'b0};
  assign pc = {1'b0, cur,   1'b0};
  assign pb = {1'b0, below, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_col
    logic [COUNT_W-1:0] n;
    assign n = COUNT_W'(pa[c]) + COUNT_W'(pa[c+1]) + COUNT_W'(pa[c+2])
             + COUNT_W'(pc[c]) + COUNT_W'(pc[c+2])
             + COUNT_W'(pb[c]) + COUNT_W'(pb[c+1]) + COUNT_W'(pb[c+2]);
    assign next_row[c] = cur[c] ? (n >= bounds.survive_low && n <= bounds.survive_high)
                                : (n >= bounds.birth_low && n <= bounds.birth_high);
  end

endmodule
